@@ sv/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int WORD_W  = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  position;
    } deq_req_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [WORD_W-1:0]  read_word;
        logic [WORD_W-1:0]  front_word;
        logic [WORD_W-1:0]  rear_word;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
    } deq_rsp_t;

    // read port address source
    typedef enum logic [2:0] {
        RD_POS,
        RD_K,
        RD_K1,
        RD_FRONT,
        RD_REAR
    } rd_sel_t;

    typedef struct packed {
        logic            load;
        logic            push_front;
        logic            push_rear;
        logic            pop_front;
        logic            pop_rear;
        logic            dec_count;
        logic            clr_k;
        logic            inc_k;
        logic            shift_wr;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            set_status;
        logic [ST_W-1:0] status_code;
        logic            cap_read;
        logic            cap_front;
        logic            cap_rear;
    } deq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            full;
        logic            empty;
        logic            pos_ok;
        logic            search_done;
        logic            match;
        logic            shift_done;
    } deq_flag_t;

endpackage

`default_nettype wire

@@ sv/deq_dp.sv @@
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: circular entry memory, front pointer, count, scan index and
// result registers. Acts on commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire deq_pkg::deq_req_t request,
    input  wire deq_pkg::deq_cmd_t cmd,
    output deq_pkg::deq_flag_t flags,
    output deq_pkg::deq_rsp_t  result
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int POSW  = deq_pkg::POS_W;
    localparam int CMPW  = (CW > POSW) ? CW : POSW;
    localparam int WW    = deq_pkg::WORD_W;
    localparam int CNTW  = deq_pkg::COUNT_W;
    localparam int STW   = deq_pkg::ST_W;
    localparam int OPW   = deq_pkg::OP_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [PW-1:0]         fp_reg, fp_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         k_reg, k_next;

    logic [OPW-1:0]        op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [POSW-1:0]       pos_reg;
    logic [STW-1:0]        status_reg;
    logic [WW-1:0]         read_word_reg;
    logic [WW-1:0]         front_word_reg;
    logic [WW-1:0]         rear_word_reg;

    logic                  empty;
    logic [CW-1:0]         rear_k;
    logic [PW-1:0]         fp_dec;
    logic [PW-1:0]         rd_addr;
    logic                  wr_en;
    logic [PW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    // physical slot of logical index k (k never exceeds DEPTH)
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] fp, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(fp) + SW'(k);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return PW'(s);
    endfunction

    assign empty  = (count_reg == '0);
    assign rear_k = empty ? '0 : count_reg - CW'(1);
    assign fp_dec = (fp_reg == '0) ? PW'(DEPTH - 1) : fp_reg - PW'(1);

    assign flags.operation   = op_reg;
    assign flags.full        = (count_reg == CW'(DEPTH));
    assign flags.empty       = empty;
    assign flags.pos_ok      = (CMPW'(pos_reg) < CMPW'(count_reg));
    assign flags.search_done = (k_reg == count_reg);
    assign flags.match       = (rdata_reg == value_reg);
    assign flags.shift_done  = ((SW'(k_reg) + SW'(1)) >= SW'(count_reg));

    always_comb
    begin
        unique case (cmd.rd_sel)
            deq_pkg::RD_POS:   rd_addr = slot(fp_reg, CW'(pos_reg));
            deq_pkg::RD_K:     rd_addr = slot(fp_reg, k_reg);
            deq_pkg::RD_K1:    rd_addr = slot(fp_reg, k_reg + CW'(1));
            deq_pkg::RD_FRONT: rd_addr = fp_reg;
            deq_pkg::RD_REAR:  rd_addr = slot(fp_reg, rear_k);
            default:           rd_addr = fp_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fp_dec;
        wr_data = value_reg;
        priority if (cmd.push_front)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.push_rear)
        begin
            wr_en   = 1'b1;
            wr_addr = slot(fp_reg, count_reg);
        end
        else if (cmd.shift_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = slot(fp_reg, k_reg);
            wr_data = rdata_reg;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        fp_next    = fp_reg;
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.push_front)
        begin
            fp_next    = fp_dec;
            count_next = count_reg + CW'(1);
        end
        if (cmd.push_rear)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop_front)
        begin
            fp_next    = slot(fp_reg, CW'(1));
            count_next = count_reg - CW'(1);
        end
        if (cmd.pop_rear || cmd.dec_count)
        begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.clr_k)
        begin
            k_next = '0;
        end
        else if (cmd.inc_k || cmd.shift_wr)
        begin
            k_next = k_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg    <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            fp_reg    <= fp_next;
            count_reg <= count_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= request.operation;
            value_reg     <= DATA_WIDTH'(request.value);
            pos_reg       <= request.position;
            status_reg    <= deq_pkg::ST_OK;
            read_word_reg <= '0;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.cap_read)
        begin
            read_word_reg <= WW'(rdata_reg);
        end
        if (cmd.cap_front)
        begin
            front_word_reg <= empty ? '0 : WW'(rdata_reg);
        end
        if (cmd.cap_rear)
        begin
            rear_word_reg <= empty ? '0 : WW'(rdata_reg);
        end
    end

    assign result.status      = status_reg;
    assign result.read_word   = read_word_reg;
    assign result.front_word  = front_word_reg;
    assign result.rear_word   = rear_word_reg;
    assign result.entry_count = CNTW'(count_reg);
    assign result.is_empty    = empty;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_fp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fp_reg < PW'(DEPTH) || PW'(DEPTH) == '0)
        else $error("front pointer out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (SW'(count_reg) == SW'($past(count_reg)) + SW'(1) ||
         SW'(count_reg) + SW'(1) == SW'($past(count_reg))))
        else $error("count moved by more than one");
`endif

endmodule

`default_nettype wire

@@ sv/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: sequences each operation, the remove search and shift, and
// the front/rear fetch, then strobes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic start,
    input  wire deq_pkg::deq_flag_t flags,
    output deq_pkg::deq_cmd_t  cmd,
    output logic               busy,
    output logic               done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_READ_CAP,
        S_FRONT_RD,
        S_REAR_RD,
        S_REAR_CAP,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = deq_pkg::RD_FRONT;

        unique case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EXEC:
            begin
                state_next = S_FRONT_RD;
                unique case (flags.operation)
                    deq_pkg::OP_PUSH_FRONT:
                    begin
                        if (flags.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_front = 1'b1;
                        end
                    end
                    deq_pkg::OP_PUSH_REAR:
                    begin
                        if (flags.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_rear = 1'b1;
                        end
                    end
                    deq_pkg::OP_POP_FRONT:
                    begin
                        if (flags.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_front = 1'b1;
                        end
                    end
                    deq_pkg::OP_POP_REAR:
                    begin
                        if (flags.empty)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_rear = 1'b1;
                        end
                    end
                    deq_pkg::OP_REMOVE:
                    begin
                        cmd.clr_k  = 1'b1;
                        state_next = S_SEARCH_RD;
                    end
                    deq_pkg::OP_READ:
                    begin
                        if (flags.pos_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = deq_pkg::RD_POS;
                            state_next = S_READ_CAP;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = deq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // unused codes: no change
                    end
                endcase
            end
            S_SEARCH_RD:
            begin
                if (flags.search_done)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = deq_pkg::ST_NOT_FOUND;
                    state_next      = S_FRONT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = deq_pkg::RD_K;
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                if (flags.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = S_SEARCH_RD;
                end
            end
            S_SHIFT_RD:
            begin
                // move later words one slot toward the front
                if (flags.shift_done)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_FRONT_RD;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = deq_pkg::RD_K1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_READ_CAP:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_FRONT_RD;
            end
            S_FRONT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = deq_pkg::RD_FRONT;
                state_next = S_REAR_RD;
            end
            S_REAR_RD:
            begin
                cmd.cap_front = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = deq_pkg::RD_REAR;
                state_next    = S_REAR_CAP;
            end
            S_REAR_CAP:
            begin
                cmd.cap_rear = 1'b1;
                state_next   = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = !(state_next == S_IDLE || state_next == S_RESP);
    assign done_next = (state_next == S_RESP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepting a word");

    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobed right after accept");
`endif

endmodule

`default_nettype wire

@@ sv/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of DEPTH words. A request word is taken when
// start is high and busy is low; its result appears on result for exactly
// one cycle with done high and cannot be held off. The entry memory has a
// single registered read port, and each memory read (search step, shift
// step, front and rear fetch) is a separate controller state. A new request
// may be taken in the same cycle that done is high. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire               logic clk,
    input  wire               logic rst_n,
    input  wire               logic start,
    output logic              busy,
    input  wire deq_pkg::deq_req_t request,
    output logic              done,
    output deq_pkg::deq_rsp_t result
);

    deq_pkg::deq_cmd_t  cmd;
    deq_pkg::deq_flag_t flags;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .flags   (flags),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ sim/double_ended_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the bounded deque. A queue-based predictor tracks
// the held words and builds the expected response for every accepted
// request. Directed tests cover the empty and full corners, removal and the
// unused operation codes. Biased random traffic then fills, drains and
// churns the deque with sender idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_top_tb;

    localparam int WORD_W  = deq_pkg::WORD_W;
    localparam int POS_W   = deq_pkg::POS_W;
    localparam int OP_W    = deq_pkg::OP_W;
    localparam int COUNT_W = deq_pkg::COUNT_W;

    localparam int DEPTH            = 16;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int RAND_PHASES      = 8;
    localparam int RAND_PHASE_ITEMS = 125;
    localparam int SETTLE_CYCLES    = 2 * DEPTH + 8;

    // codes with no defined operation; the block must leave the deque alone
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    deq_pkg::deq_req_t request;
    logic              done;
    deq_pkg::deq_rsp_t result;

    logic [WORD_W-1:0] deque_words[$];
    deq_pkg::deq_rsp_t pending_results[$];

    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int empty_pops      = 0;
    int removes_matched = 0;
    int peak_fill       = 0;
    int cycle_count     = 0;

    double_ended_queue_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_results.size());
            $display("FAIL double_ended_queue_top");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("%0t ns: mismatch on %s, got %h expected %h", $time, field, got, want);
        error_count++;
    endtask

    function automatic deq_pkg::deq_req_t make_request(input logic [OP_W-1:0] op,
                                                       input logic [WORD_W-1:0] val,
                                                       input logic [POS_W-1:0] pos);
        deq_pkg::deq_req_t req;
        req.operation = op;
        req.value     = val;
        req.position  = pos;
        return req;
    endfunction

    // Predictor: applies one request to the held words and returns the response.
    function automatic deq_pkg::deq_rsp_t apply_operation(input deq_pkg::deq_req_t req);
        deq_pkg::deq_rsp_t rsp;
        int                hit;
        rsp        = '0;
        rsp.status = deq_pkg::ST_OK;
        hit        = -1;
        case (req.operation)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR:
            begin
                if (deque_words.size() >= DEPTH)
                begin
                    rsp.status = deq_pkg::ST_FULL;
                    full_refusals++;
                end
                else if (req.operation == deq_pkg::OP_PUSH_FRONT)
                    deque_words.push_front(req.value);
                else
                    deque_words.push_back(req.value);
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR:
            begin
                if (deque_words.size() == 0)
                begin
                    rsp.status = deq_pkg::ST_EMPTY;
                    empty_pops++;
                end
                else if (req.operation == deq_pkg::OP_POP_FRONT)
                    void'(deque_words.pop_front());
                else
                    void'(deque_words.pop_back());
            end
            deq_pkg::OP_REMOVE:
            begin
                foreach (deque_words[k])
                    if (hit < 0 && deque_words[k] == req.value)
                        hit = k;
                if (hit < 0)
                    rsp.status = deq_pkg::ST_NOT_FOUND;
                else
                begin
                    deque_words.delete(hit);
                    removes_matched++;
                end
            end
            deq_pkg::OP_READ:
            begin
                if (req.position < deque_words.size())
                    rsp.read_word = deque_words[req.position];
                else
                    rsp.status = deq_pkg::ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        rsp.entry_count = COUNT_W'(deque_words.size());
        rsp.is_empty    = (deque_words.size() == 0);
        if (deque_words.size() != 0)
        begin
            rsp.front_word = deque_words[0];
            rsp.rear_word  = deque_words[deque_words.size() - 1];
        end
        if (deque_words.size() > peak_fill)
            peak_fill = deque_words.size();
        return rsp;
    endfunction

    // Caller sits just after a rising edge; returns at the accepting edge.
    task automatic send_word(input deq_pkg::deq_req_t req);
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_operation(req));
        words_sent++;
    endtask

    task automatic idle_cycles(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        deq_pkg::deq_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected response", result.front_word, '0);
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result.status !== want.status)
                    report_mismatch("status", WORD_W'(result.status),
                                    WORD_W'(want.status));
                if (result.read_word !== want.read_word)
                    report_mismatch("read_word", result.read_word, want.read_word);
                if (result.front_word !== want.front_word)
                    report_mismatch("front_word", result.front_word, want.front_word);
                if (result.rear_word !== want.rear_word)
                    report_mismatch("rear_word", result.rear_word, want.rear_word);
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", WORD_W'(result.entry_count),
                                    WORD_W'(want.entry_count));
                if (result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", WORD_W'(result.is_empty),
                                    WORD_W'(want.is_empty));
            end
        end
    end

    // small or all-ones/all-zeros values half the time so pushes repeat and removes find duplicates
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 1) ? {WORD_W{1'b1}} : {WORD_W{1'b0}};
            default: return $urandom();
        endcase
    endfunction

    // mode 0 leans to pushes, mode 1 to pops, mode 2 is balanced
    function automatic deq_pkg::deq_req_t random_request(input int mode);
        int                roll;
        int                push_pct;
        int                pop_pct;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] val;
        logic [POS_W-1:0]  pos;
        push_pct = (mode == 0) ? 55 : (mode == 1) ? 15 : 35;
        pop_pct  = (mode == 1) ? 55 : (mode == 0) ? 15 : 30;
        roll     = $urandom_range(0, 99);
        val      = pick_value();
        pos      = POS_W'($urandom_range(0, 15));
        if (roll < push_pct)
            op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR;
        else if (roll < push_pct + pop_pct)
            op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_REAR;
        else if (roll < 97)
        begin
            if ($urandom_range(0, 1))
            begin
                op = deq_pkg::OP_REMOVE;
                if (deque_words.size() != 0 && $urandom_range(0, 9) < 6)
                    val = deque_words[$urandom_range(0, deque_words.size() - 1)];
            end
            else
            begin
                op = deq_pkg::OP_READ;
                if (deque_words.size() != 0 && $urandom_range(0, 9) < 8)
                    pos = POS_W'($urandom_range(0, deque_words.size() - 1));
            end
        end
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        return make_request(op, val, pos);
    endfunction

    task automatic test_empty_deque();
        send_word(make_request(deq_pkg::OP_POP_FRONT, '0, '0));
        send_word(make_request(deq_pkg::OP_POP_REAR, {WORD_W{1'b1}}, '1));
        send_word(make_request(deq_pkg::OP_REMOVE, '0, '0));
        send_word(make_request(deq_pkg::OP_READ, '0, '0));
        wait_results_done();
    endtask

    task automatic test_full_deque();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            // extremes first, then distinct patterns on alternating ends
            if (i == 0)
                send_word(make_request(deq_pkg::OP_PUSH_REAR, {WORD_W{1'b1}}, '0));
            else if (i == 1)
                send_word(make_request(deq_pkg::OP_PUSH_FRONT, '0, '1));
            else
                send_word(make_request(i[0] ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR,
                                       32'hA5C3_0000 | (32'h1 << (i + 15)) | i,
                                       POS_W'(i)));
        end
        send_word(make_request(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, '0));
        send_word(make_request(deq_pkg::OP_PUSH_REAR, 32'h0000_0001, '0));
        send_word(make_request(deq_pkg::OP_READ, '0, '0));
        send_word(make_request(deq_pkg::OP_READ, '0, '1));
        wait_results_done();
    endtask

    task automatic test_remove_and_spare_codes();
        // middle entry, then the rear entry, then a value not held
        send_word(make_request(deq_pkg::OP_REMOVE, deque_words[DEPTH / 2], '0));
        send_word(make_request(deq_pkg::OP_REMOVE, deque_words[deque_words.size() - 1], '0));
        send_word(make_request(deq_pkg::OP_REMOVE, 32'h1234_5678, '0));
        send_word(make_request(OP_SPARE_A, {WORD_W{1'b1}}, '1));
        send_word(make_request(OP_SPARE_B, '0, '0));
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        int  phase;
        int  n;
        bit  quiet;
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            quiet = (phase == RAND_PHASES - 1);
            for (n = 0; n < RAND_PHASE_ITEMS; n++)
            begin
                if (!quiet && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 8));
                send_word(random_request(phase % 3));
            end
            // on odd phases, hold off until the block has answered everything
            if (phase % 2 == 1)
                wait_results_done();
        end
        wait_results_done();
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_full_deque();
        test_remove_and_spare_codes();
        test_random_traffic();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d request words, %0d responses checked, peak fill %0d of %0d",
                 words_sent, results_checked, peak_fill, DEPTH);
        $display("full refusals %0d, empty pops %0d, removes that matched %0d",
                 full_refusals, empty_pops, removes_matched);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS double_ended_queue_top");
        else
            $display("FAIL double_ended_queue_top");
        $finish;
    end

endmodule
